### hw/rtl/swdh_pkg.sv
// ----------------------------------------------------------------------------
// swdh_pkg
// Shared types and codes for the SWD host transfer engine.
// ----------------------------------------------------------------------------
package swdh_pkg;

    localparam int DEF_MAX_SEQ_BITS = 64;

    localparam int SEQ_LEN_W  = 7;   // width of the sequence length field
    localparam int BIT_CNT_W  = 6;   // holds 33 and any sequence bit index
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // request types
    localparam logic [1:0] REQ_TICK   = 2'd0;
    localparam logic [1:0] REQ_XFER   = 2'd1;
    localparam logic [1:0] REQ_SEQOUT = 2'd2;
    localparam logic [1:0] REQ_SEQIN  = 2'd3;

    // acknowledge patterns, first received bit in bit 0
    localparam logic [2:0] ACK_OK    = 3'b001;
    localparam logic [2:0] ACK_WAIT  = 3'b010;
    localparam logic [2:0] ACK_FAULT = 3'b100;

    // status codes
    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_WAIT   = 3'd1;
    localparam logic [2:0] ST_FAULT  = 3'd2;
    localparam logic [2:0] ST_PARITY = 3'd3;
    localparam logic [2:0] ST_NOACK  = 3'd4;

    // register indexes
    localparam logic [1:0] REG_TURNAROUND = 2'd0;
    localparam logic [1:0] REG_DRAIN      = 2'd1;
    localparam logic [1:0] REG_IDLE       = 2'd2;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_REQ,
        PH_TRN_ACK,
        PH_ACK,
        PH_RDATA,
        PH_TRN_DATA,
        PH_WDATA,
        PH_IDLECYC,
        PH_SEQOUT,
        PH_SEQIN
    } t_phase;

    typedef struct packed {
        logic [1:0]           req_type;
        logic [3:0]           req_bits;
        logic [31:0]          write_word;
        logic [SEQ_LEN_W-1:0] seq_length;
        logic [63:0]          seq_bits;
        logic                 line_sample;
    } t_item;

    typedef struct packed {
        logic [2:0] turnaround_ticks;
        logic       drain_data_phase;
        logic [7:0] idle_after_transfer;
    } t_cfg;

    typedef struct packed {
        logic        line_drive;
        logic        line_enable;
        logic        op_done;
        logic [2:0]  ack_raw;
        logic [2:0]  status_code;
        logic [63:0] read_bits;
    } t_result;

endpackage

### hw/rtl/swdh_cfg.sv
// ----------------------------------------------------------------------------
// swdh_cfg
// APB register file: turnaround length, drain mode, idle cycle count.
// ----------------------------------------------------------------------------
module swdh_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [swdh_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [swdh_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [swdh_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready,
    output swdh_pkg::t_cfg                   o_cfg
);
    import swdh_pkg::*;

    logic [1:0] w_index;
    logic       w_wr;
    t_cfg       r_cfg;

    assign pready  = 1'b1;
    assign w_index = paddr[3:2];
    assign w_wr    = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.turnaround_ticks    <= 3'd1;
            r_cfg.drain_data_phase    <= 1'b0;
            r_cfg.idle_after_transfer <= 8'd0;
        end else if (w_wr) begin
            case (w_index)
                REG_TURNAROUND: r_cfg.turnaround_ticks    <= pwdata[2:0];
                REG_DRAIN:      r_cfg.drain_data_phase    <= pwdata[0];
                REG_IDLE:       r_cfg.idle_after_transfer <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_index)
            REG_TURNAROUND: prdata = APB_DATA_W'(r_cfg.turnaround_ticks);
            REG_DRAIN:      prdata = APB_DATA_W'(r_cfg.drain_data_phase);
            REG_IDLE:       prdata = APB_DATA_W'(r_cfg.idle_after_transfer);
            default:        prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

### hw/rtl/swdh_seq.sv
// ----------------------------------------------------------------------------
// swdh_seq
// SWD bit sequencer: phase state, shift registers and per-tick result.
// ----------------------------------------------------------------------------
module swdh_seq #(
    parameter int MAX_SEQ_BITS = swdh_pkg::DEF_MAX_SEQ_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  swdh_pkg::t_item   i_item,
    input  swdh_pkg::t_cfg    i_cfg,
    output logic              o_res_valid,
    output swdh_pkg::t_result o_res
);
    import swdh_pkg::*;

    localparam int OUT_W = (MAX_SEQ_BITS > 41) ? MAX_SEQ_BITS : 41;
    localparam int IN_W  = (MAX_SEQ_BITS > 32) ? MAX_SEQ_BITS : 32;
    localparam int IDX_W = $clog2(IN_W);
    localparam int CNT_W = $clog2(MAX_SEQ_BITS + 1);
    localparam logic [SEQ_LEN_W-1:0] MAX_LEN = SEQ_LEN_W'(MAX_SEQ_BITS);

    t_phase               r_phase,     n_phase;
    logic [BIT_CNT_W-1:0] r_bit_cnt,   n_bit_cnt;
    logic                 r_req_rnw,   n_req_rnw;
    logic [OUT_W-1:0]     r_out_shift, n_out_shift;
    logic [IN_W-1:0]      r_in_shift,  n_in_shift;
    logic [2:0]           r_ack,       n_ack;
    logic                 r_parity,    n_parity;
    logic [7:0]           r_idle_cnt,  n_idle_cnt;
    logic [CNT_W-1:0]     r_seq_rem,   n_seq_rem;

    logic                 w_tick, w_cmd, w_done, w_s;
    logic [BIT_CNT_W-1:0] w_ta, w_bc_dec, w_rd_off;
    logic [CNT_W-1:0]     w_seq_len;
    logic                 w_last, w_ack_ok, w_ack_wf, w_new_ok, w_new_wf, w_idle_none;
    logic [2:0]           w_ack_new;
    logic [1:0]           w_ack_pos;
    logic [IDX_W-1:0]     w_in_idx;
    logic [IN_W-1:0]      w_in_set;
    logic [OUT_W-1:0]     w_out_shr;

    assign w_s         = i_item.line_sample;
    assign w_tick      = i_step && (i_item.req_type == REQ_TICK);
    assign w_cmd       = i_step && (i_item.req_type != REQ_TICK) && (r_phase == PH_IDLE);
    assign w_bc_dec    = r_bit_cnt - BIT_CNT_W'(1);
    assign w_last      = (r_bit_cnt == BIT_CNT_W'(1));
    assign w_ack_ok    = (r_ack == ACK_OK);
    assign w_ack_wf    = (r_ack == ACK_WAIT) || (r_ack == ACK_FAULT);
    assign w_idle_none = (i_cfg.idle_after_transfer == 8'd0);
    assign w_out_shr   = {1'b0, r_out_shift[OUT_W-1:1]};

    // ack bits arrive with counter 3,2,1 -> positions 0,1,2
    assign w_ack_pos = 2'd3 - r_bit_cnt[1:0];
    assign w_ack_new = r_ack | (3'(w_s) << w_ack_pos);
    assign w_new_ok  = (w_ack_new == ACK_OK);
    assign w_new_wf  = (w_ack_new == ACK_WAIT) || (w_ack_new == ACK_FAULT);

    // read data bit position: counter 33 -> bit 0
    assign w_rd_off = BIT_CNT_W'(33) - r_bit_cnt;
    assign w_in_idx = (r_phase == PH_SEQIN) ? r_bit_cnt[IDX_W-1:0] : IDX_W'(w_rd_off[4:0]);

    always_comb begin
        w_in_set           = r_in_shift;
        w_in_set[w_in_idx] = r_in_shift[w_in_idx] | w_s;
    end

    // turnaround length, clamped to 1..4
    always_comb begin
        case (i_cfg.turnaround_ticks)
            3'd0:    w_ta = BIT_CNT_W'(1);
            3'd1:    w_ta = BIT_CNT_W'(1);
            3'd2:    w_ta = BIT_CNT_W'(2);
            3'd3:    w_ta = BIT_CNT_W'(3);
            default: w_ta = BIT_CNT_W'(4);
        endcase
    end

    always_comb begin
        if (i_item.seq_length == '0 || i_item.seq_length > MAX_LEN) begin
            w_seq_len = CNT_W'(MAX_SEQ_BITS);
        end else begin
            w_seq_len = CNT_W'(i_item.seq_length);
        end
    end

    // per-tick output and end-of-operation detect
    always_comb begin
        o_res_valid = 1'b0;
        o_res       = '0;
        w_done      = 1'b0;
        if (w_tick) begin
            case (r_phase)
                PH_IDLE: ;
                PH_REQ: begin
                    o_res_valid       = 1'b1;
                    o_res.line_enable = 1'b1;
                    o_res.line_drive  = r_out_shift[0];
                end
                PH_TRN_ACK, PH_ACK, PH_RDATA: o_res_valid = 1'b1;
                PH_TRN_DATA: begin
                    o_res_valid = 1'b1;
                    if (w_last) begin
                        if (w_ack_ok) begin
                            w_done = r_req_rnw && w_idle_none;
                        end else begin
                            w_done = !(w_ack_wf && i_cfg.drain_data_phase && !r_req_rnw);
                        end
                    end
                end
                PH_WDATA: begin
                    o_res_valid       = 1'b1;
                    o_res.line_enable = 1'b1;
                    o_res.line_drive  = r_out_shift[0];
                    w_done            = w_last && (!w_ack_ok || w_idle_none);
                end
                PH_IDLECYC: begin
                    o_res_valid       = 1'b1;
                    o_res.line_enable = 1'b1;
                    w_done            = (r_idle_cnt == 8'd1);
                end
                PH_SEQOUT: begin
                    o_res_valid       = 1'b1;
                    o_res.line_enable = 1'b1;
                    o_res.line_drive  = r_out_shift[0];
                    w_done            = (r_seq_rem == CNT_W'(1));
                end
                PH_SEQIN: begin
                    o_res_valid = 1'b1;
                    w_done      = (r_seq_rem == CNT_W'(1));
                end
                default: ;
            endcase
        end
        o_res.op_done = w_done;
        if (w_done) begin
            if (r_phase == PH_SEQIN) begin
                o_res.read_bits = 64'(w_in_set);
            end else if (r_phase != PH_SEQOUT) begin
                o_res.ack_raw = r_ack;
                if (w_ack_ok) begin
                    if (r_req_rnw) begin
                        o_res.read_bits   = 64'(r_in_shift[31:0]);
                        o_res.status_code = r_parity ? ST_PARITY : ST_OK;
                    end
                end else if (r_ack == ACK_WAIT) begin
                    o_res.status_code = ST_WAIT;
                end else if (r_ack == ACK_FAULT) begin
                    o_res.status_code = ST_FAULT;
                end else begin
                    o_res.status_code = ST_NOACK;
                end
            end
        end
    end

    // next state
    always_comb begin
        n_phase     = r_phase;
        n_bit_cnt   = r_bit_cnt;
        n_req_rnw   = r_req_rnw;
        n_out_shift = r_out_shift;
        n_in_shift  = r_in_shift;
        n_ack       = r_ack;
        n_parity    = r_parity;
        n_idle_cnt  = r_idle_cnt;
        n_seq_rem   = r_seq_rem;
        if (w_cmd) begin
            case (i_item.req_type)
                REQ_XFER: begin
                    // start, APnDP, RnW, A[3:2], parity, stop, park, data, parity
                    n_req_rnw   = i_item.req_bits[1];
                    n_out_shift = OUT_W'({^i_item.write_word, i_item.write_word,
                                          1'b1, 1'b0, ^i_item.req_bits,
                                          i_item.req_bits, 1'b1});
                    n_in_shift  = '0;
                    n_ack       = 3'd0;
                    n_parity    = 1'b0;
                    n_bit_cnt   = BIT_CNT_W'(8);
                    n_phase     = PH_REQ;
                end
                REQ_SEQOUT: begin
                    n_out_shift = OUT_W'(i_item.seq_bits[MAX_SEQ_BITS-1:0]);
                    n_seq_rem   = w_seq_len;
                    n_phase     = PH_SEQOUT;
                end
                REQ_SEQIN: begin
                    n_in_shift = '0;
                    n_seq_rem  = w_seq_len;
                    n_bit_cnt  = '0;
                    n_phase    = PH_SEQIN;
                end
                default: ;
            endcase
        end else if (w_tick) begin
            case (r_phase)
                PH_IDLE: ;
                PH_REQ: begin
                    n_out_shift = w_out_shr;
                    n_bit_cnt   = w_bc_dec;
                    if (w_last) begin
                        n_phase   = PH_TRN_ACK;
                        n_bit_cnt = w_ta;
                    end
                end
                PH_TRN_ACK: begin
                    n_bit_cnt = w_bc_dec;
                    if (w_last) begin
                        n_phase   = PH_ACK;
                        n_bit_cnt = BIT_CNT_W'(3);
                    end
                end
                PH_ACK: begin
                    n_ack     = w_ack_new;
                    n_bit_cnt = w_bc_dec;
                    if (w_last) begin
                        if (w_new_ok) begin
                            n_phase   = r_req_rnw ? PH_RDATA : PH_TRN_DATA;
                            n_bit_cnt = r_req_rnw ? BIT_CNT_W'(33) : w_ta;
                        end else if (w_new_wf) begin
                            // drained write phase drives zeros
                            n_out_shift = '0;
                            if (i_cfg.drain_data_phase && r_req_rnw) begin
                                n_phase   = PH_RDATA;
                                n_bit_cnt = BIT_CNT_W'(33);
                            end else begin
                                n_phase   = PH_TRN_DATA;
                                n_bit_cnt = w_ta;
                            end
                        end else begin
                            n_phase   = PH_RDATA;
                            n_bit_cnt = BIT_CNT_W'(33);
                        end
                    end
                end
                PH_RDATA: begin
                    if (w_ack_ok) begin
                        if (!w_last) begin
                            n_in_shift = w_in_set;
                        end
                        n_parity = r_parity ^ w_s;
                    end
                    n_bit_cnt = w_bc_dec;
                    if (w_last) begin
                        n_phase   = PH_TRN_DATA;
                        n_bit_cnt = w_ta;
                    end
                end
                PH_TRN_DATA: begin
                    n_bit_cnt = w_bc_dec;
                    if (w_last) begin
                        if (w_ack_ok && r_req_rnw) begin
                            n_phase    = PH_IDLECYC;
                            n_idle_cnt = i_cfg.idle_after_transfer;
                        end else if (w_ack_ok ||
                                     (w_ack_wf && i_cfg.drain_data_phase)) begin
                            n_phase   = PH_WDATA;
                            n_bit_cnt = BIT_CNT_W'(33);
                        end
                    end
                end
                PH_WDATA: begin
                    n_out_shift = w_out_shr;
                    n_bit_cnt   = w_bc_dec;
                    if (w_last) begin
                        n_phase    = PH_IDLECYC;
                        n_idle_cnt = i_cfg.idle_after_transfer;
                    end
                end
                PH_IDLECYC: n_idle_cnt = r_idle_cnt - 8'd1;
                PH_SEQOUT: begin
                    n_out_shift = w_out_shr;
                    n_seq_rem   = r_seq_rem - CNT_W'(1);
                end
                PH_SEQIN: begin
                    n_in_shift = w_in_set;
                    n_bit_cnt  = r_bit_cnt + BIT_CNT_W'(1);
                    n_seq_rem  = r_seq_rem - CNT_W'(1);
                end
                default: n_phase = PH_IDLE;
            endcase
            // done overrides any phase move chosen above
            if (w_done) begin
                n_phase   = PH_IDLE;
                n_bit_cnt = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_bit_cnt  <= '0;
            r_idle_cnt <= 8'd0;
            r_seq_rem  <= '0;
        end else begin
            r_phase    <= n_phase;
            r_bit_cnt  <= n_bit_cnt;
            r_idle_cnt <= n_idle_cnt;
            r_seq_rem  <= n_seq_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req_rnw   <= n_req_rnw;
        r_out_shift <= n_out_shift;
        r_in_shift  <= n_in_shift;
        r_ack       <= n_ack;
        r_parity    <= n_parity;
    end

endmodule

### hw/rtl/swd_host_transfer_engine.sv
// ----------------------------------------------------------------------------
// swd_host_transfer_engine
// Bit-level SWD host: transfers, output sequences and input sequences.
// ----------------------------------------------------------------------------
// One word is accepted per clock on the input channel. A command word (type
// transfer, output sequence or input sequence) starts an operation when the
// engine is idle and gives no result; a command that arrives while busy is
// dropped. Each tick word that follows is one SWCLK period and gives exactly
// one result word: the SWDIO drive value and enable for that period, with
// op_done, ack, status and read data on the operation's last tick. Ticks
// while idle give nothing. Each word waits in the input register until the
// result register can take it, and its result is then registered in the
// result register, from which it is offered on the result port until taken.
// The engine sustains one word per cycle as long as the result side is
// not stalled; the phase state update (one bit per tick) is the only loop. A
// stalled result register holds the input register, which then stalls the
// input. Configuration registers over APB (turnaround at 0x0, drain mode at
// 0x4, idle count at 0x8) must only change while no operation is in flight.
// SWDIO is released during turnarounds and acknowledge/read phases, and a
// drained WAIT/FAULT write drives 33 zero bits.
// ----------------------------------------------------------------------------
module swd_host_transfer_engine #(
    parameter int MAX_SEQ_BITS = swdh_pkg::DEF_MAX_SEQ_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [1:0]                          i_req_type,
    input  logic [3:0]                          i_req_bits,
    input  logic [31:0]                         i_write_word,
    input  logic [swdh_pkg::SEQ_LEN_W-1:0]      i_seq_length,
    input  logic [63:0]                         i_seq_bits,
    input  logic                                i_line_sample,
    // result channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_clock_active,
    output logic                                o_line_drive,
    output logic                                o_line_enable,
    output logic                                o_op_done,
    output logic [2:0]                          o_ack_raw,
    output logic [2:0]                          o_status_code,
    output logic [63:0]                         o_read_bits,
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [swdh_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [swdh_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [swdh_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import swdh_pkg::*;

    t_cfg    w_cfg;
    t_item   r_item;
    logic    r_in_valid;
    logic    w_adv;       // result register can take a new word
    logic    w_step;      // sequencer consumes the input register
    logic    w_res_valid;
    t_result w_res;
    t_result r_res;
    logic    r_out_valid;

    swdh_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // handshake: the input register moves whenever the result register is
    // empty or being drained this cycle
    assign w_adv      = !r_out_valid || !i_out_stall;
    assign w_step     = r_in_valid && w_adv;
    assign o_in_stall = r_in_valid && !w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_item.req_type    <= i_req_type;
            r_item.req_bits    <= i_req_bits;
            r_item.write_word  <= i_write_word;
            r_item.seq_length  <= i_seq_length;
            r_item.seq_bits    <= i_seq_bits;
            r_item.line_sample <= i_line_sample;
        end
    end

    swdh_seq #(
        .MAX_SEQ_BITS (MAX_SEQ_BITS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_step),
        .i_item      (r_item),
        .i_cfg       (w_cfg),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_step && w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step && w_res_valid) begin
            r_res <= w_res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_clock_active = 1'b1;   // every result word is one SWCLK period
    assign o_line_drive   = r_res.line_drive;
    assign o_line_enable  = r_res.line_enable;
    assign o_op_done      = r_res.op_done;
    assign o_ack_raw      = r_res.ack_raw;
    assign o_status_code  = r_res.status_code;
    assign o_read_bits    = r_res.read_bits;

    // released line never carries a drive value
    a_released_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_line_enable |-> !o_line_drive)
        else $error("line driven while released");

    // ack, status and data only on the final tick
    a_done_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_op_done |->
            o_ack_raw == 3'd0 && o_status_code == ST_OK && o_read_bits == 64'd0)
        else $error("completion fields set before op_done");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_status_code <= ST_NOACK)
        else $error("status code out of range");

    // input stalls only behind a full, stalled result register
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without downstream backpressure");

endmodule
